FILE: design/ray_scene_closest_hit_macros.svh
// Assertion macros shared by the closest-hit block's modules.
`ifndef RAY_SCENE_CLOSEST_HIT_MACROS_SVH
`define RAY_SCENE_CLOSEST_HIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RSCH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define RSCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rsch_pkg.sv
// Shared types and constants of the closest-hit ray tracer.
package rsch_pkg;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TRACE = 1'b1;

   // Primitive shapes
   localparam logic [1:0] SHAPE_RECT_Z = 2'd0;
   localparam logic [1:0] SHAPE_RECT_X = 2'd1;
   localparam logic [1:0] SHAPE_RECT_Y = 2'd2;
   localparam logic [1:0] SHAPE_SPHERE = 2'd3;

   // Table entry: shape above five 32-bit parameters
   localparam int PARAM_W = 32;
   localparam int ENTRY_W = 2 + 5 * PARAM_W;

   // Sphere root threshold (1e-4 in Q16.16) and distance ceiling
   localparam logic signed [33:0] EPS_Q = 34'sd6;
   localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

   // Datapath operations
   typedef enum logic [3:0] {
      DP_NOP,
      DP_WRITE,
      DP_TRACE,
      DP_READ,
      DP_SETUP,
      DP_SAT,
      DP_DIV_INIT,
      DP_DIV,
      DP_QLOAD,
      DP_RECT_T,
      DP_BSAT,
      DP_SQRT_INIT,
      DP_SQRT,
      DP_SPH_T,
      DP_NEXT,
      DP_RESP
   } dp_op_type;

   // Multiplier operand selects
   typedef enum logic [3:0] {
      MS_NONE,
      MS_DU,
      MS_DV,
      MS_OPXD,
      MS_OPYD,
      MS_OPZD,
      MS_OPX2,
      MS_OPY2,
      MS_OPZ2,
      MS_RR,
      MS_BB
   } mul_sel_type;

   // Product accumulate targets
   typedef enum logic [2:0] {
      AC_NONE,
      AC_CU,
      AC_CV,
      AC_B,
      AC_OO,
      AC_DET
   } acc_sel_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type mul_sel;
      acc_sel_type acc_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic cur_valid;
      logic is_sphere;
      logic rect_miss;
      logic rect_sat;
      logic iter_last;
      logic q_zero;
      logic det_neg;
      logic idx_last;
   } dp_status_type;

endpackage

FILE: design/ray_scene_closest_hit.sv
// Top level of the closest-hit ray tracer over a table of rectangles and spheres.
//
//   channel   ports                             handshake
//   request   req_kind/slot/shape/val_a..val_f  start & !busy
//   response  rsp_hit/hit_index/distance        rsp_valid strobe, one cycle
//
// A write word leaves the controller idle; its all-zero response strobes on the next cycle.
// A trace word scans every table entry through one shared multiplier and a
// 2-bit-per-cycle divider / square root; empty entries skip the table read.
// Reset clears the valid bits at once; table contents are undefined until written.
// busy stays high through a scan; the receiver cannot stall responses.
module ray_scene_closest_hit import rsch_pkg::*; #(
   parameter int MAX_OBJECTS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_kind,
   input  logic [4:0]         req_slot,
   input  logic [1:0]         req_shape,
   input  logic signed [31:0] req_val_a,
   input  logic signed [31:0] req_val_b,
   input  logic signed [31:0] req_val_c,
   input  logic signed [31:0] req_val_d,
   input  logic signed [31:0] req_val_e,
   input  logic signed [31:0] req_val_f,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [4:0]         rsp_hit_index,
   output logic [30:0]        rsp_distance
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rsch_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   rsch_dpath #(.MAX_OBJECTS(MAX_OBJECTS)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_slot      (req_slot),
      .req_shape     (req_shape),
      .req_val_a     (req_val_a),
      .req_val_b     (req_val_b),
      .req_val_c     (req_val_c),
      .req_val_d     (req_val_d),
      .req_val_e     (req_val_e),
      .req_val_f     (req_val_f),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_hit_index (rsp_hit_index),
      .rsp_distance  (rsp_distance)
   );

endmodule

FILE: design/rsch_dpath.sv
// Datapath: scene table, shared multiplier, divider, square root and best-hit tracking.
`include "ray_scene_closest_hit_macros.svh"

module rsch_dpath import rsch_pkg::*; #(
   parameter int MAX_OBJECTS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [4:0]          req_slot,
   input  logic [1:0]          req_shape,
   input  logic signed [31:0]  req_val_a,
   input  logic signed [31:0]  req_val_b,
   input  logic signed [31:0]  req_val_c,
   input  logic signed [31:0]  req_val_d,
   input  logic signed [31:0]  req_val_e,
   input  logic signed [31:0]  req_val_f,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic [4:0]          rsp_hit_index,
   output logic [30:0]         rsp_distance
);

   localparam int IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

   // Saturate a signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sh0_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -50'sh0_0000_8000_0000) begin
         r = -32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Scene table
   logic [ENTRY_W-1:0]     mem [MAX_OBJECTS];
   logic [ENTRY_W-1:0]     rd_ff;
   logic [MAX_OBJECTS-1:0] valid_ff;

   // Ray
   logic signed [31:0] ox_ff, oy_ff, oz_ff, dx_ff, dy_ff, dz_ff;

   // Scan and best hit
   logic [IW-1:0] idx_ff, best_idx_ff;
   logic          found_ff, cand_ff;
   logic [30:0]   best_ff, tsat_ff;

   // Rectangle and divider
   logic          rect_miss_ff, rect_sat_ff;
   logic [48:0]   div_n_ff;
   logic [31:0]   div_d_ff, rem_ff, lo_ff, q_ff;
   logic [3:0]    iter_ff;
   logic signed [49:0] cu_ff, cv_ff;

   // Sphere and square root
   logic signed [31:0] opx_ff, opy_ff, opz_ff, b_ff;
   logic signed [49:0] bsum_ff;
   logic [63:0]        oo_ff, det_ff, sq_lo_ff;
   logic [32:0]        sq_rem_ff;
   logic [31:0]        root_ff;

   // Multiplier
   logic signed [63:0] prod_ff, prod_sh;
   logic signed [31:0] ma, mb;

   // Response
   logic        rsp_valid_ff, rsp_hit_ff;
   logic [4:0]  rsp_idx_ff;
   logic [30:0] rsp_dist_ff;

   // Entry fields
   logic signed [31:0] pa, pb, pc, pd, pe;
   logic [1:0]         rshape;
   assign pa     = rd_ff[31:0];
   assign pb     = rd_ff[63:32];
   assign pc     = rd_ff[95:64];
   assign pd     = rd_ff[127:96];
   assign pe     = rd_ff[159:128];
   assign rshape = rd_ff[161:160];

   // Write decode
   logic [8:0]    slot_ext;
   logic          slot_ok;
   logic [IW-1:0] wr_idx;
   assign slot_ext = {4'b0, req_slot};
   assign slot_ok  = slot_ext < 9'(MAX_OBJECTS);
   assign wr_idx   = IW'(slot_ext);

   // Select plane axis and in-plane axes
   logic signed [31:0] ax_o, ax_d, u_o, u_d, v_o, v_d;
   always_comb begin
      case (rshape)
         SHAPE_RECT_X: begin
            ax_o = ox_ff; ax_d = dx_ff;
            u_o = oy_ff; u_d = dy_ff; v_o = oz_ff; v_d = dz_ff;
         end
         SHAPE_RECT_Y: begin
            ax_o = oy_ff; ax_d = dy_ff;
            u_o = ox_ff; u_d = dx_ff; v_o = oz_ff; v_d = dz_ff;
         end
         default: begin
            ax_o = oz_ff; ax_d = dz_ff;
            u_o = ox_ff; u_d = dx_ff; v_o = oy_ff; v_d = dy_ff;
         end
      endcase
   end

   // Rectangle setup: signed numerator, divisor magnitude, saturation check
   logic signed [32:0] num;
   logic signed [33:0] nn;
   logic [31:0]        dmag;
   logic [48:0]        nmag;
   logic               setup_miss, setup_sat;
   always_comb begin
      num        = {pe[31], pe} - {ax_o[31], ax_o};
      nn         = ax_d[31] ? -{num[32], num} : {num[32], num};
      dmag       = ax_d[31] ? (~ax_d + 32'd1) : ax_d;
      nmag       = {nn[32:0], 16'b0};
      setup_miss = (ax_d == 32'sd0) || nn[33] || (nn == 34'sd0);
      setup_sat  = {14'b0, nmag} >= {dmag, 31'b0};
   end

   // Two restoring division steps
   logic [32:0] r1, r2;
   logic [31:0] r1n, r2n;
   logic        ge1, ge2;
   always_comb begin
      r1  = {rem_ff, lo_ff[31]};
      ge1 = r1 >= {1'b0, div_d_ff};
      r1n = ge1 ? 32'(r1 - {1'b0, div_d_ff}) : r1[31:0];
      r2  = {r1n, lo_ff[30]};
      ge2 = r2 >= {1'b0, div_d_ff};
      r2n = ge2 ? 32'(r2 - {1'b0, div_d_ff}) : r2[31:0];
   end

   // Two square-root digit steps
   logic [34:0] sa1, st1, sa2, st2;
   logic [32:0] srem1, srem2;
   logic [31:0] sroot1;
   logic        sge1, sge2;
   always_comb begin
      sa1    = {sq_rem_ff, sq_lo_ff[63:62]};
      st1    = {1'b0, root_ff, 2'b01};
      sge1   = sa1 >= st1;
      srem1  = sge1 ? 33'(sa1 - st1) : sa1[32:0];
      sroot1 = {root_ff[30:0], sge1};
      sa2    = {srem1, sq_lo_ff[61:60]};
      st2    = {1'b0, sroot1, 2'b01};
      sge2   = sa2 >= st2;
      srem2  = sge2 ? 33'(sa2 - st2) : sa2[32:0];
   end

   // Sphere distance candidates
   logic signed [33:0] t1, t2, tc;
   logic               sph_hit;
   always_comb begin
      t1      = {{2{b_ff[31]}}, b_ff} - {2'b0, root_ff};
      t2      = {{2{b_ff[31]}}, b_ff} + {2'b0, root_ff};
      tc      = (t1 > EPS_Q) ? t1 : t2;
      sph_hit = (t1 > EPS_Q) || (t2 > EPS_Q);
   end

   // Rectangle bounds check
   logic rect_in;
   always_comb begin
      rect_in = (cu_ff >= 50'(pa)) && (cu_ff <= 50'(pb)) &&
                (cv_ff >= 50'(pc)) && (cv_ff <= 50'(pd));
   end

   // Multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MS_DU:   begin ma = u_d;    mb = {1'b0, tsat_ff}; end
         MS_DV:   begin ma = v_d;    mb = {1'b0, tsat_ff}; end
         MS_OPXD: begin ma = opx_ff; mb = dx_ff;  end
         MS_OPYD: begin ma = opy_ff; mb = dy_ff;  end
         MS_OPZD: begin ma = opz_ff; mb = dz_ff;  end
         MS_OPX2: begin ma = opx_ff; mb = opx_ff; end
         MS_OPY2: begin ma = opy_ff; mb = opy_ff; end
         MS_OPZ2: begin ma = opz_ff; mb = opz_ff; end
         MS_RR:   begin ma = pd;     mb = pd;     end
         MS_BB:   begin ma = b_ff;   mb = b_ff;   end
         default: begin ma = 32'sd0; mb = 32'sd0; end
      endcase
   end
   assign prod_sh = prod_ff >>> 16;

   // Table storage: write on write items, read one entry per scan step
   always_ff @(posedge clock) begin
      if (cmd.op == DP_WRITE && slot_ok) begin
         mem[wr_idx] <= {req_shape, req_val_e, req_val_d, req_val_c, req_val_b, req_val_a};
      end
      if (cmd.op == DP_READ) begin
         rd_ff <= mem[idx_ff];
      end
   end

   // Control registers: valid bits and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.op == DP_WRITE) || (cmd.op == DP_RESP);
         if (cmd.op == DP_WRITE && slot_ok) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // Arithmetic and scan registers
   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;

      // accumulate the previous product
      case (cmd.acc_sel)
         AC_CU:   cu_ff   <= 50'(u_o) + prod_sh[49:0];
         AC_CV:   cv_ff   <= 50'(v_o) + prod_sh[49:0];
         AC_B:    bsum_ff <= bsum_ff + prod_sh[49:0];
         AC_OO:   oo_ff   <= oo_ff + 64'(prod_ff);
         AC_DET:  det_ff  <= det_ff + 64'(prod_ff);
         default: ;
      endcase

      unique case (cmd.op)
         DP_TRACE: begin
            ox_ff <= req_val_a; oy_ff <= req_val_b; oz_ff <= req_val_c;
            dx_ff <= req_val_d; dy_ff <= req_val_e; dz_ff <= req_val_f;
            idx_ff      <= '0;
            best_idx_ff <= '0;
            best_ff     <= '0;
            found_ff    <= 1'b0;
            cand_ff     <= 1'b0;
         end
         DP_SETUP: begin
            rect_miss_ff <= setup_miss;
            rect_sat_ff  <= setup_sat;
            div_n_ff     <= nmag;
            div_d_ff     <= dmag;
            opx_ff  <= sat32(50'(pa) - 50'(ox_ff));
            opy_ff  <= sat32(50'(pb) - 50'(oy_ff));
            opz_ff  <= sat32(50'(pc) - 50'(oz_ff));
            bsum_ff <= '0;
            oo_ff   <= '0;
            det_ff  <= '0;
         end
         DP_SAT: tsat_ff <= DIST_MAX;
         DP_DIV_INIT: begin
            rem_ff  <= {15'b0, div_n_ff[48:32]};
            lo_ff   <= div_n_ff[31:0];
            q_ff    <= '0;
            iter_ff <= '0;
         end
         DP_DIV: begin
            rem_ff  <= r2n;
            lo_ff   <= {lo_ff[29:0], 2'b00};
            q_ff    <= {q_ff[29:0], ge1, ge2};
            iter_ff <= iter_ff + 4'd1;
         end
         DP_QLOAD:  tsat_ff <= q_ff[30:0];
         DP_RECT_T: cand_ff <= rect_in;
         DP_BSAT:   b_ff    <= sat32(bsum_ff);
         DP_SQRT_INIT: begin
            sq_lo_ff  <= det_ff - oo_ff;
            sq_rem_ff <= '0;
            root_ff   <= '0;
            iter_ff   <= '0;
         end
         DP_SQRT: begin
            sq_lo_ff  <= {sq_lo_ff[59:0], 4'b0};
            sq_rem_ff <= srem2;
            root_ff   <= {sroot1[30:0], sge2};
            iter_ff   <= iter_ff + 4'd1;
         end
         DP_SPH_T: begin
            cand_ff <= sph_hit;
            tsat_ff <= (tc > 34'(DIST_MAX)) ? DIST_MAX : tc[30:0];
         end
         DP_NEXT: begin
            // keep the nearest hit, lower index wins ties
            if (cand_ff && (!found_ff || tsat_ff < best_ff)) begin
               found_ff    <= 1'b1;
               best_ff     <= tsat_ff;
               best_idx_ff <= idx_ff;
            end
            cand_ff <= 1'b0;
            idx_ff  <= idx_ff + 1'b1;
         end
         DP_RESP: begin
            rsp_hit_ff  <= found_ff;
            rsp_idx_ff  <= found_ff ? 5'({{8{1'b0}}, best_idx_ff}) : 5'd0;
            rsp_dist_ff <= found_ff ? best_ff : 31'd0;
         end
         DP_WRITE: begin
            rsp_hit_ff  <= 1'b0;
            rsp_idx_ff  <= 5'd0;
            rsp_dist_ff <= 31'd0;
         end
         default: ;
      endcase
   end

   // Status to controller
   always_comb begin
      status.cur_valid = valid_ff[idx_ff];
      status.is_sphere = (rshape == SHAPE_SPHERE);
      status.rect_miss = rect_miss_ff;
      status.rect_sat  = rect_sat_ff;
      status.iter_last = (iter_ff == 4'd15);
      status.q_zero    = (q_ff == 32'd0);
      status.det_neg   = (det_ff < oo_ff);
      status.idx_last  = (idx_ff == IW'(MAX_OBJECTS - 1));
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_index = rsp_idx_ff;
   assign rsp_distance  = rsp_dist_ff;

   `RSCH_ASSERT_IMPL(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, rsp_dist_ff == 31'd0 && rsp_idx_ff == 5'd0, "miss word carries nonzero fields")
   `RSCH_ASSERT_IMPL(a_hit_has_dist, clock, reset, rsp_valid_ff && rsp_hit_ff, rsp_dist_ff != 31'd0, "hit word with zero distance")

endmodule

FILE: design/rsch_ctrl.sv
// Controller: sequences table writes and the per-entry intersection steps.
`include "ray_scene_closest_hit_macros.svh"

module rsch_ctrl import rsch_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_kind,
   output logic          busy,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE, S_READ, S_SETUP, S_ROUTE, S_DIV, S_RQ,
      S_R0, S_R1, S_R2, S_R3,
      S_SM0, S_SM1, S_SM2, S_SM3, S_SM4, S_SM5, S_SM6, S_SM7, S_SM8,
      S_DETCHK, S_SQRT, S_SPH_T, S_NEXT, S_RESP
   } state_type;

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode commands and next state
   always_comb begin
      state_in    = state_ff;
      cmd.op      = DP_NOP;
      cmd.mul_sel = MS_NONE;
      cmd.acc_sel = AC_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_kind == KIND_TRACE) begin
                  cmd.op   = DP_TRACE;
                  state_in = S_READ;
               end else begin
                  cmd.op = DP_WRITE;
               end
            end
         end
         S_READ: begin
            if (status.cur_valid) begin
               cmd.op   = DP_READ;
               state_in = S_SETUP;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_SETUP: begin
            cmd.op   = DP_SETUP;
            state_in = S_ROUTE;
         end
         S_ROUTE: begin
            if (status.is_sphere) begin
               state_in = S_SM0;
            end else if (status.rect_miss) begin
               state_in = S_NEXT;
            end else if (status.rect_sat) begin
               cmd.op   = DP_SAT;
               state_in = S_R0;
            end else begin
               cmd.op   = DP_DIV_INIT;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.op = DP_DIV;
            if (status.iter_last) begin
               state_in = S_RQ;
            end
         end
         S_RQ: begin
            // a zero quotient is no forward hit
            if (status.q_zero) begin
               state_in = S_NEXT;
            end else begin
               cmd.op   = DP_QLOAD;
               state_in = S_R0;
            end
         end
         S_R0: begin
            cmd.mul_sel = MS_DU;
            state_in    = S_R1;
         end
         S_R1: begin
            cmd.mul_sel = MS_DV;
            cmd.acc_sel = AC_CU;
            state_in    = S_R2;
         end
         S_R2: begin
            cmd.acc_sel = AC_CV;
            state_in    = S_R3;
         end
         S_R3: begin
            cmd.op   = DP_RECT_T;
            state_in = S_NEXT;
         end
         S_SM0: begin
            cmd.mul_sel = MS_OPXD;
            state_in    = S_SM1;
         end
         S_SM1: begin
            cmd.mul_sel = MS_OPYD;
            cmd.acc_sel = AC_B;
            state_in    = S_SM2;
         end
         S_SM2: begin
            cmd.mul_sel = MS_OPZD;
            cmd.acc_sel = AC_B;
            state_in    = S_SM3;
         end
         S_SM3: begin
            cmd.mul_sel = MS_OPX2;
            cmd.acc_sel = AC_B;
            state_in    = S_SM4;
         end
         S_SM4: begin
            cmd.op      = DP_BSAT;
            cmd.mul_sel = MS_OPY2;
            cmd.acc_sel = AC_OO;
            state_in    = S_SM5;
         end
         S_SM5: begin
            cmd.mul_sel = MS_OPZ2;
            cmd.acc_sel = AC_OO;
            state_in    = S_SM6;
         end
         S_SM6: begin
            cmd.mul_sel = MS_RR;
            cmd.acc_sel = AC_OO;
            state_in    = S_SM7;
         end
         S_SM7: begin
            cmd.mul_sel = MS_BB;
            cmd.acc_sel = AC_DET;
            state_in    = S_SM8;
         end
         S_SM8: begin
            cmd.acc_sel = AC_DET;
            state_in    = S_DETCHK;
         end
         S_DETCHK: begin
            if (status.det_neg) begin
               state_in = S_NEXT;
            end else begin
               cmd.op   = DP_SQRT_INIT;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = DP_SQRT;
            if (status.iter_last) begin
               state_in = S_SPH_T;
            end
         end
         S_SPH_T: begin
            cmd.op   = DP_SPH_T;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            cmd.op   = DP_NEXT;
            state_in = status.idx_last ? S_RESP : S_READ;
         end
         S_RESP: begin
            cmd.op   = DP_RESP;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `RSCH_ASSERT_IMPL(a_idle_cmds, clock, reset, !busy, cmd.op == DP_NOP || cmd.op == DP_WRITE || cmd.op == DP_TRACE, "scan command issued while idle")
   `RSCH_ASSERT_NEXT(a_trace_busy, clock, reset, start && !busy && req_kind == KIND_TRACE, busy, "trace word did not start a scan")

endmodule
